[sv/tdpt_pkg.sv]
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared widths, constants and controller/datapath interface types for the
// trial-division prime test core.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int VALUE_WIDTH = 32;
    // divisor never exceeds floor(sqrt(2^(VALUE_WIDTH-1))) + 1
    localparam int DIV_WIDTH   = (VALUE_WIDTH + 2) / 2;
    localparam int SQ_WIDTH    = 2 * DIV_WIDTH;
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

    localparam logic [CNT_WIDTH-1:0]   CNT_START     = CNT_WIDTH'(VALUE_WIDTH - 1);
    localparam logic [DIV_WIDTH-1:0]   FIRST_DIVISOR = DIV_WIDTH'(2);
    localparam logic [SQ_WIDTH-1:0]    FIRST_SQUARE  = SQ_WIDTH'(4);
    localparam logic [VALUE_WIDTH-1:0] SMALLEST_PRIME = VALUE_WIDTH'(2);

    typedef struct packed {
        logic load;       // capture a new request
        logic start_div;  // clear remainder, arm bit counter
        logic div_step;   // one restoring division step
        logic next_div;   // advance divisor and its square
    } tdpt_cmd_t;

    typedef struct packed {
        logic trivial;    // negative, zero or one
        logic bound_over; // divisor squared exceeds value
        logic div_last;   // current step is the last division step
        logic rem_zero;   // remainder is zero
    } tdpt_status_t;

endpackage

[sv/tdpt_dp.sv]
// ----------------------------------------------------------------------------
// tdpt_dp
// Datapath: value, divisor, running square and a bit-serial restoring
// remainder unit producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_dp
    import tdpt_pkg::*;
(
    input  logic                   aclk,
    input  tdpt_cmd_t              cmd,
    input  logic [VALUE_WIDTH-1:0] s_test_value,
    output tdpt_status_t           status
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [DIV_WIDTH-1:0]   divisor_reg;
    logic [SQ_WIDTH-1:0]    square_reg;
    logic [DIV_WIDTH-1:0]   rem_reg;
    logic [DIV_WIDTH-1:0]   rem_next;
    logic [CNT_WIDTH-1:0]   cnt_reg;
    logic [DIV_WIDTH:0]     trial;

    always_comb begin
        trial = {rem_reg, value_reg[cnt_reg]};
        if (trial >= {1'b0, divisor_reg}) begin
            rem_next = DIV_WIDTH'(trial - {1'b0, divisor_reg});
        end else begin
            rem_next = trial[DIV_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg   <= s_test_value;
            divisor_reg <= FIRST_DIVISOR;
            square_reg  <= FIRST_SQUARE;
        end else if (cmd.next_div) begin
            divisor_reg <= divisor_reg + DIV_WIDTH'(1);
            square_reg  <= square_reg + SQ_WIDTH'({divisor_reg, 1'b1});
        end
        if (cmd.start_div) begin
            rem_reg <= '0;
            cnt_reg <= CNT_START;
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CNT_WIDTH'(1);
        end
    end

    assign status.trivial    = value_reg[VALUE_WIDTH-1] || (value_reg < SMALLEST_PRIME);
    assign status.bound_over = square_reg > {{(SQ_WIDTH-VALUE_WIDTH){1'b0}}, value_reg};
    assign status.div_last   = (cnt_reg == '0);
    assign status.rem_zero   = (rem_reg == '0);

endmodule

[sv/tdpt_ctrl.sv]
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Controller: sequences bound check, remainder and test per divisor, and
// holds the result register of the output channel.
// ----------------------------------------------------------------------------
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    output logic         m_is_prime,
    output tdpt_cmd_t    cmd,
    input  tdpt_status_t status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUND,
        S_DIV,
        S_TEST,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   prime_reg;
    logic   m_valid_reg;
    logic   m_is_prime_reg;
    logic   accept;
    logic   out_free;

    assign s_ready    = (state_reg == S_IDLE);
    assign accept     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_is_prime_reg;
    assign out_free   = !m_valid_reg || m_ready;

    always_comb begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.start_div = (state_reg == S_BOUND) && !status.trivial && !status.bound_over;
        cmd.div_step  = (state_reg == S_DIV);
        cmd.next_div  = (state_reg == S_TEST) && !status.rem_zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            prime_reg   <= 1'b0;
        end else begin
            // in S_DONE the result register is reloaded below instead
            if (m_valid_reg && m_ready && (state_reg != S_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_BOUND;
                    end
                end
                S_BOUND: begin
                    if (status.trivial) begin
                        prime_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end else if (status.bound_over) begin
                        prime_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (status.div_last) begin
                        state_reg <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (status.rem_zero) begin
                        prime_reg <= 1'b0;
                        state_reg <= S_DONE;
                    end else begin
                        state_reg <= S_BOUND;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_is_prime_reg <= prime_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_accept_to_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_BOUND)
        else $error("request accepted without entering bound check");

    a_div_to_test: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && status.div_last) |=> state_reg == S_TEST)
        else $error("division did not finish into test");

    a_factor_not_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TEST && status.rem_zero) |=> (state_reg == S_DONE && !prime_reg))
        else $error("factor found but result not cleared");

    a_trivial_not_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BOUND && status.trivial) |=> !prime_reg)
        else $error("value below two reported as prime");

endmodule

[sv/trial_division_prime_test_core.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test_core
// Tests one signed integer per request for primality by trial division.
//
// Input channel s_valid/s_ready carries s_test_value (two's complement).
// Output channel m_valid/m_ready carries m_is_prime, one result per request.
// One request is worked on at a time; s_ready is high only when idle.
// Negative values, zero and one finish at the bound check with no division.
// Otherwise each trial divisor d (2, 3, ... while d*d <= value) takes one bound
// check, a bit-serial restoring remainder over all 32 value bits and one zero test.
// Run time grows with k, the divisors tried (smallest factor - 1, or
// floor(sqrt(value)) - 1 for a prime), and is longest for the largest
// primes; the shared remainder unit sets it. The result sits in an output
// register, so a new request is taken while the previous result waits; if
// the receiver still stalls when the next result is ready, the core holds
// it and waits.
// Synchronous active-low reset returns the core to idle with no result
// pending; nothing is kept between requests.
// ----------------------------------------------------------------------------
module trial_division_prime_test_core
    import tdpt_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_test_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_is_prime
);

    tdpt_cmd_t    cmd;
    tdpt_status_t status;

    tdpt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_is_prime (m_is_prime),
        .cmd        (cmd),
        .status     (status)
    );

    tdpt_dp u_dp (
        .aclk         (aclk),
        .cmd          (cmd),
        .s_test_value (s_test_value),
        .status       (status)
    );

endmodule
